// ----- rtl/core/ckw_pkg.sv -----
package ckw_pkg;

   localparam int MAX_KNOTS = 16;
   localparam int SLOT_W    = $clog2(MAX_KNOTS);
   localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
   localparam int ADDR_W    = 3;

   localparam logic [1:0] MODE_SPLINE = 2'd0;
   localparam logic [1:0] MODE_SPLIT  = 2'd1;
   localparam logic [1:0] MODE_LINEAR = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_COUNT = 1'b1;

   localparam logic signed [63:0] Q_ONE = 64'sd65536;

   typedef struct packed {
      logic               cmd;
      logic [3:0]         knot_slot;
      logic signed [31:0] knot_time;
      logic signed [31:0] t_value;
      logic signed [31:0] multiplier;
   } req_type;

   typedef struct packed {
      logic [3:0]         shape_slot;
      logic signed [31:0] weight;
      logic               last;
   } rsp_type;

   // clamp a wide signed value to the Q16.16 range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // divide by two, rounding toward zero
   function automatic logic signed [63:0] half64(input logic signed [63:0] v);
      logic signed [63:0] a;
      a = v + (v[63] ? 64'sd1 : 64'sd0);
      return a >>> 1;
   endfunction

   // Q16.16 product scaling: drop 16 fraction bits toward zero, then clamp
   function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
      logic signed [63:0] a;
      a = p + (p[63] ? 64'sd65535 : 64'sd0);
      return sat32(a >>> 16);
   endfunction

endpackage

// ----- rtl/core/catmull_rom_knot_weights.sv -----
// Catmull-Rom knot weights. Load items (cmd 0) write one knot time into a
// 16-entry table; they give no result. Evaluate items (cmd 1) scan the first
// knot_count entries (clamped to 16), pick the interval that holds t_value and
// emit two to four items of (shape_slot, weight), the final one with last set.
// interp_mode selects spline (0), split spline that keeps only knots on the
// side of zero where t lies (1) or linear (2 and 3). Knots must be loaded in
// ascending order. All values are signed Q16.16 and saturate. Fewer than two
// selected knots give no result. One item is worked at a time; an evaluate
// passes through the one-entry-per-cycle table scan, the 49-step restoring
// divider for the position in the interval and the shared 32x32 multiplier
// that forms x^2, x^3 and each scaled weight, and waits out output stalls.
// Registers: interp_mode at byte address 0, knot_count at byte address 4.
module catmull_rom_knot_weights (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ckw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ckw_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import ckw_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_SCAN   = 12'b000000000010,
      ST_DECIDE = 12'b000000000100,
      ST_DIV    = 12'b000000001000,
      ST_POSX   = 12'b000000010000,
      ST_LINW   = 12'b000000100000,
      ST_SQ     = 12'b000001000000,
      ST_CUBE_A = 12'b000010000000,
      ST_CUBE_B = 12'b000100000000,
      ST_BASIS  = 12'b001000000000,
      ST_WMUL   = 12'b010000000000,
      ST_WPUT   = 12'b100000000000
   } state_type;

   typedef enum logic [1:0] {IV_FIRST, IV_MID, IV_LAST} iv_type;

   // knot table, one synchronous read port
   logic signed [31:0] knot_mem [MAX_KNOTS];
   logic signed [31:0] rdata_ff;

   state_type state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [31:0] t_ff, t_in, mul_ff, mul_in;
   logic [CNT_W-1:0] scan_ff, scan_in, seln_ff, seln_in;
   logic rdv_ff, rdv_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic signed [31:0] f0_ff, f0_in, f1_ff, f1_in;
   logic [SLOT_W-1:0]  fs_ff [3], fs_in [3];
   logic signed [31:0] wt_ff [3], wt_in [3];
   logic [SLOT_W-1:0]  ws_ff [3], ws_in [3];
   logic found_ff, found_in, pend_ff, pend_in;
   logic [SLOT_W-1:0] mi_ff, mi_in;
   logic signed [31:0] mlo_ff, mlo_in, mhi_ff, mhi_in;
   logic [SLOT_W-1:0]  ms_ff [4], ms_in [4];
   logic lin_ff, lin_in, out_ff, out_in, qneg_ff, qneg_in, dz_ff, dz_in;
   iv_type cls_ff, cls_in;
   logic [48:0] dvd_ff, dvd_in;
   logic [32:0] rem_ff, rem_in, den_ff, den_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic signed [31:0] x_ff, x_in, x2_ff, x2_in;
   logic signed [63:0] p_ff, p_in;
   logic signed [31:0] v_ff [4], v_in [4];
   logic signed [31:0] pw_ff [4], pw_in [4];
   logic [SLOT_W-1:0]  ps_ff [4], ps_in [4];
   logic [2:0] rcnt_ff, rcnt_in;
   logic [1:0] k_ff, k_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0] cnt_eff;
   logic csr_wr, req_acc, take, out_free;
   logic signed [31:0] lo, hi;
   logic signed [32:0] num, den;
   logic [32:0] nmag;
   logic [33:0] trial;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] x64, x2e, x3e, v0e, v1e, v2e, v3e;
   iv_type cls_d;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cnt_eff   = (count_ff > CNT_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS) : count_ff;

   always_comb begin
      case (paddr[2])
         REG_MODE: prdata = {30'd0, mode_ff};
         default:  prdata = {{(32 - CNT_W){1'b0}}, count_ff};
      endcase
   end

   // table write on load, one read per cycle during the scan
   always_ff @(posedge clock) begin
      if (req_acc && req_data.cmd == CMD_LOAD) begin
         knot_mem[req_data.knot_slot] <= req_data.knot_time;
      end
      rdata_ff <= knot_mem[scan_ff[SLOT_W-1:0]];
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ:    begin mul_a = x_ff;   mul_b = x_ff;      end
         ST_CUBE_B: begin mul_a = x2_ff; mul_b = x_ff;      end
         ST_WMUL:  begin mul_a = mul_ff; mul_b = pw_ff[k_ff]; end
         default:  begin mul_a = '0;     mul_b = '0;        end
      endcase
   end

   always_comb begin
      // defaults: hold
      state_in = state_ff;   mode_in = mode_ff;     count_in = count_ff;
      t_in = t_ff;           mul_in = mul_ff;       scan_in = scan_ff;
      seln_in = seln_ff;     rdv_in = 1'b0;         rslot_in = scan_ff[SLOT_W-1:0];
      f0_in = f0_ff;         f1_in = f1_ff;         fs_in = fs_ff;
      wt_in = wt_ff;         ws_in = ws_ff;         found_in = found_ff;
      pend_in = pend_ff;     mi_in = mi_ff;         mlo_in = mlo_ff;
      mhi_in = mhi_ff;       ms_in = ms_ff;         lin_in = lin_ff;
      out_in = out_ff;       qneg_in = qneg_ff;     dz_in = dz_ff;
      cls_in = cls_ff;       dvd_in = dvd_ff;       rem_in = rem_ff;
      den_in = den_ff;       dcnt_in = dcnt_ff;     x_in = x_ff;
      x2_in = x2_ff;         p_in = p_ff;           v_in = v_ff;
      pw_in = pw_ff;         ps_in = ps_ff;         rcnt_in = rcnt_ff;
      k_in = k_ff;           rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      take = 1'b0; lo = '0; hi = '0; num = '0; den = '0; nmag = '0;
      trial = '0; cls_d = IV_FIRST;
      x64 = 64'(x_ff);
      x2e = 64'(x2_ff);
      x3e = qscale(p_ff);
      v0e = '0; v1e = '0; v2e = '0; v3e = '0;

      if (csr_wr) begin
         case (paddr[2])
            REG_MODE: mode_in  = pwdata[1:0];
            default:  count_in = pwdata[CNT_W-1:0];
         endcase
      end

      if (state_ff == ST_WMUL || state_ff == ST_SQ || state_ff == ST_CUBE_B) begin
         p_in = mul_a * mul_b;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.cmd == CMD_EVAL) begin
               t_in     = req_data.t_value;
               mul_in   = req_data.multiplier;
               scan_in  = '0;
               seln_in  = '0;
               found_in = 1'b0;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read per cycle, process the entry returned last cycle
            if (scan_ff < cnt_eff) begin
               rdv_in  = 1'b1;
               scan_in = scan_ff + 1'b1;
            end else if (!rdv_ff) begin
               state_in = ST_DECIDE;
            end
            if (rdv_ff) begin
               take = 1'b1;
               if (mode_ff == MODE_SPLIT) begin
                  take = t_ff[31] ? (rdata_ff <= 0) : !rdata_ff[31];
               end
               if (take) begin
                  if (seln_ff == 0) begin f0_in = rdata_ff; fs_in[0] = rslot_ff; end
                  if (seln_ff == 1) begin f1_in = rdata_ff; fs_in[1] = rslot_ff; end
                  if (seln_ff == 2) fs_in[2] = rslot_ff;
                  if (pend_ff) begin
                     ms_in[3] = rslot_ff;
                     pend_in  = 1'b0;
                  end
                  // first interval that holds t
                  if (seln_ff != 0 && !found_ff && wt_ff[2] <= t_ff && t_ff < rdata_ff) begin
                     found_in = 1'b1;
                     pend_in  = 1'b1;
                     mi_in    = SLOT_W'(seln_ff - 1'b1);
                     mlo_in   = wt_ff[2];
                     mhi_in   = rdata_ff;
                     ms_in[0] = ws_ff[1];
                     ms_in[1] = ws_ff[2];
                     ms_in[2] = rslot_ff;
                  end
                  wt_in[0] = wt_ff[1]; wt_in[1] = wt_ff[2]; wt_in[2] = rdata_ff;
                  ws_in[0] = ws_ff[1]; ws_in[1] = ws_ff[2]; ws_in[2] = rslot_ff;
                  seln_in = seln_ff + 1'b1;
               end
            end
         end
         ST_DECIDE: begin
            if (t_ff >= wt_ff[1]) begin
               cls_d = IV_LAST;  lo = wt_ff[1]; hi = wt_ff[2];
            end else if (t_ff < f0_ff) begin
               cls_d = IV_FIRST; lo = f0_ff;    hi = f1_ff;
            end else if (found_ff && (CNT_W'(mi_ff) + CNT_W'(3) <= seln_ff)
                         && mi_ff != 0) begin
               cls_d = IV_MID;   lo = mlo_ff;   hi = mhi_ff;
            end else begin
               cls_d = IV_FIRST; lo = f0_ff;    hi = f1_ff;
            end
            cls_in = cls_d;
            out_in = (t_ff < f0_ff) || (t_ff > wt_ff[2]);
            lin_in = mode_ff[1] || (seln_ff == 2) || (t_ff < f0_ff && t_ff > wt_ff[2]);
            num     = 33'(t_ff) - 33'(lo);
            den     = 33'(hi) - 33'(lo);
            nmag    = num[32] ? 33'(-num) : 33'(num);
            dvd_in  = {nmag[32:0], 16'd0};
            den_in  = den[32] ? 33'(-den) : 33'(den);
            qneg_in = num[32] ^ den[32];
            dz_in   = (den == 0);
            rem_in  = '0;
            dcnt_in = 6'd49;
            state_in = (seln_ff < 2) ? ST_IDLE : ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit per cycle
            trial = {rem_ff, dvd_ff[48]};
            if (trial >= {1'b0, den_ff}) begin
               rem_in = 33'(trial - {1'b0, den_ff});
               dvd_in = {dvd_ff[47:0], 1'b1};
            end else begin
               rem_in = trial[32:0];
               dvd_in = {dvd_ff[47:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == 6'd1) state_in = ST_POSX;
         end
         ST_POSX: begin
            if (dz_ff) x_in = '0;
            else x_in = sat32(qneg_ff ? -64'(dvd_ff) : 64'(dvd_ff));
            state_in = (lin_ff || out_ff) ? ST_LINW : ST_SQ;
         end
         ST_LINW: begin
            pw_in[0] = sat32(Q_ONE - x64);
            pw_in[1] = x_ff;
            case (cls_ff)
               IV_MID:  begin ps_in[0] = ms_ff[1]; ps_in[1] = ms_ff[2]; end
               IV_LAST: begin ps_in[0] = ws_ff[1]; ps_in[1] = ws_ff[2]; end
               default: begin ps_in[0] = fs_ff[0]; ps_in[1] = fs_ff[1]; end
            endcase
            if (!lin_ff && cls_ff != IV_FIRST) begin
               // beyond the last knot: far end first
               pw_in[0] = x_ff;
               pw_in[1] = sat32(Q_ONE - x64);
               ps_in[0] = ws_ff[2];
               ps_in[1] = ws_ff[1];
            end
            rcnt_in  = 3'd2;
            k_in     = '0;
            state_in = ST_WMUL;
         end
         ST_SQ: begin
            state_in = ST_CUBE_A;
         end
         ST_CUBE_A: begin
            x2_in    = qscale(p_ff);
            state_in = ST_CUBE_B;
         end
         ST_CUBE_B: begin
            state_in = ST_BASIS;
         end
         ST_BASIS: begin
            v0e = -half64(x3e) + x2e - half64(x64);
            v1e = half64(3 * x3e) - half64(5 * x2e) + Q_ONE;
            v2e = -half64(3 * x3e) + 2 * x2e + half64(x64);
            v3e = half64(x3e) - half64(x2e);
            v_in[0] = sat32(v0e);
            v_in[1] = sat32(v1e);
            v_in[2] = sat32(v2e);
            v_in[3] = sat32(v3e);
            state_in = ST_LINW;
            // fold end tangents in the cycle after, reuse ST_WMUL entry below
            state_in = ST_WMUL;
            k_in     = '0;
            rcnt_in  = 3'd0;
         end
         ST_WMUL: begin
            // first pass after the basis: fold into per-knot weights
            if (rcnt_ff == 3'd0) begin
               case (cls_ff)
                  IV_FIRST: begin
                     pw_in[0] = sat32(64'(v_ff[1]) + 64'(v_ff[0]) + 64'(v_ff[0]));
                     pw_in[1] = sat32(64'(v_ff[2]) - 64'(v_ff[0]));
                     pw_in[2] = v_ff[3];
                     ps_in[0] = fs_ff[0]; ps_in[1] = fs_ff[1]; ps_in[2] = fs_ff[2];
                     rcnt_in  = 3'd3;
                  end
                  IV_LAST: begin
                     pw_in[0] = v_ff[0];
                     pw_in[1] = sat32(64'(v_ff[1]) - 64'(v_ff[3]));
                     pw_in[2] = sat32(64'(v_ff[2]) + 64'(v_ff[3]) + 64'(v_ff[3]));
                     ps_in[0] = ws_ff[0]; ps_in[1] = ws_ff[1]; ps_in[2] = ws_ff[2];
                     rcnt_in  = 3'd3;
                  end
                  default: begin
                     pw_in = v_ff;
                     ps_in = ms_ff;
                     rcnt_in = 3'd4;
                  end
               endcase
               p_in = p_ff;
            end else begin
               state_in = ST_WPUT;
            end
         end
         ST_WPUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.shape_slot = ps_ff[k_ff];
               rsp_data_in.weight     = qscale(p_ff);
               rsp_data_in.last       = (3'(k_ff) + 3'd1 == rcnt_ff);
               k_in = k_ff + 1'b1;
               state_in = (3'(k_ff) + 3'd1 == rcnt_ff) ? ST_IDLE : ST_WMUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SPLINE;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff <= t_in;       mul_ff <= mul_in;     scan_ff <= scan_in;
      seln_ff <= seln_in; rslot_ff <= rslot_in; f0_ff <= f0_in;
      f1_ff <= f1_in;     fs_ff <= fs_in;       wt_ff <= wt_in;
      ws_ff <= ws_in;     found_ff <= found_in; pend_ff <= pend_in;
      mi_ff <= mi_in;     mlo_ff <= mlo_in;     mhi_ff <= mhi_in;
      ms_ff <= ms_in;     lin_ff <= lin_in;     out_ff <= out_in;
      qneg_ff <= qneg_in; dz_ff <= dz_in;       cls_ff <= cls_in;
      dvd_ff <= dvd_in;   rem_ff <= rem_in;     den_ff <= den_in;
      dcnt_ff <= dcnt_in; x_ff <= x_in;         x2_ff <= x2_in;
      p_ff <= p_in;       v_ff <= v_in;         pw_ff <= pw_in;
      ps_ff <= ps_in;     rcnt_ff <= rcnt_in;   k_ff <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- sim/catmull_rom_knot_weights_tb.sv -----
`timescale 1ns / 100ps

module catmull_rom_knot_weights_tb;
   import ckw_pkg::*;

   // Q16.16 constants of the Catmull-Rom basis
   localparam longint Q_HALF     = 32768;
   localparam longint Q_ONE_HALF = 98304;
   localparam longint Q_TWO      = 131072;
   localparam longint Q_TWO_HALF = 163840;
   localparam int     PHASES     = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // items waiting to be offered, and weights the block still owes us
   req_type pending_items[$];
   rsp_type weights_due[$];

   // shadow copy of the block's table and registers
   int       knot_shadow [0:MAX_KNOTS-1];
   logic [1:0] mode_shadow = MODE_SPLINE;
   logic [4:0] count_shadow = '0;

   // knots picked for the current evaluation
   int sel_time [0:MAX_KNOTS-1];
   int sel_slot [0:MAX_KNOTS-1];
   rsp_type batch[$];

   int errors = 0;
   int items_in = 0;
   int weights_out = 0;
   int evals_in = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   always #10 clock = ~clock;

   catmull_rom_knot_weights DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // ---------------------------------------------------------------------
   // Fixed-point helpers: truncate toward zero, clamp to 32 bits
   // ---------------------------------------------------------------------
   function automatic int clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic longint prod64(input longint a, input longint b);
      return (a * b) / Q_ONE;
   endfunction

   function automatic int mulq(input int a, input int b);
      return clamp32(prod64(a, b));
   endfunction

   // position of t within [lo, hi]; a zero-length segment maps to 0
   function automatic int seg_pos(input int t, input int lo, input int hi);
      longint num, den;
      num = longint'(t) - longint'(lo);
      den = longint'(hi) - longint'(lo);
      if (den == 0) return 0;
      return clamp32((num * Q_ONE) / den);
   endfunction

   function automatic void emit(input int slot, input int w);
      rsp_type r;
      r.shape_slot = slot[3:0];
      r.weight     = w;
      r.last       = 1'b0;
      batch.push_back(r);
   endfunction

   // interval search over the selected knots, run as written (no sorting)
   function automatic int locate(input int n, input int t, output bit outside);
      outside = (t < sel_time[0]) || (t > sel_time[n-1]);
      if (t >= sel_time[n-2]) return n - 2;
      if (t < sel_time[0]) return 0;
      for (int i = 0; i < n - 2; i++) begin
         if (sel_time[i] <= t && t < sel_time[i+1]) return i;
      end
      return 0;
   endfunction

   function automatic void blend_two(input int n, input int t, input int mul);
      bit out_flag;
      int idx, u;
      if (n < 2) return;
      idx = locate(n, t, out_flag);
      u   = seg_pos(t, sel_time[idx], sel_time[idx+1]);
      emit(sel_slot[idx], mulq(mul, clamp32(Q_ONE - u)));
      emit(sel_slot[idx+1], mulq(mul, u));
   endfunction

   function automatic void blend_cubic(input int n, input int t, input int mul);
      bit out_flag;
      int iv, x, x2, x3, v0, v1, v2, v3, inv;
      if (n <= 2 || (t < sel_time[0] && t > sel_time[n-1])) begin
         blend_two(n, t, mul);
         return;
      end
      iv = locate(n, t, out_flag);
      x  = seg_pos(t, sel_time[iv], sel_time[iv+1]);
      if (out_flag) begin
         // extrapolate linearly off the nearest end segment
         inv = clamp32(Q_ONE - x);
         if (iv == 0) begin
            emit(sel_slot[0], mulq(mul, inv));
            emit(sel_slot[1], mulq(mul, x));
         end else begin
            emit(sel_slot[n-1], mulq(mul, x));
            emit(sel_slot[n-2], mulq(mul, inv));
         end
         return;
      end
      x2 = mulq(x, x);
      x3 = mulq(x2, x);
      v0 = clamp32(-prod64(Q_HALF, x3) + prod64(Q_ONE, x2) - prod64(Q_HALF, x));
      v1 = clamp32(prod64(Q_ONE_HALF, x3) - prod64(Q_TWO_HALF, x2) + Q_ONE);
      v2 = clamp32(-prod64(Q_ONE_HALF, x3) + prod64(Q_TWO, x2) + prod64(Q_HALF, x));
      v3 = clamp32(prod64(Q_HALF, x3) - prod64(Q_HALF, x2));
      if (iv == 0) begin
         // fold the start tangent into the first knot
         emit(sel_slot[0], mulq(mul, clamp32(longint'(v1) + v0 + v0)));
         emit(sel_slot[1], mulq(mul, clamp32(longint'(v2) - v0)));
         emit(sel_slot[2], mulq(mul, v3));
      end else if (iv == n - 2) begin
         // fold the end tangent into the last knot
         emit(sel_slot[n-3], mulq(mul, v0));
         emit(sel_slot[n-2], mulq(mul, clamp32(longint'(v1) - v3)));
         emit(sel_slot[n-1], mulq(mul, clamp32(longint'(v2) + v3 + v3)));
      end else begin
         emit(sel_slot[iv-1], mulq(mul, v0));
         emit(sel_slot[iv],   mulq(mul, v1));
         emit(sel_slot[iv+1], mulq(mul, v2));
         emit(sel_slot[iv+2], mulq(mul, v3));
      end
   endfunction

   // work out the weights one accepted item owes, and queue them
   function automatic void predict_weights(input req_type it);
      int n, cnt, k, t;
      bit take;
      n = 0;
      if (it.cmd == CMD_LOAD) begin
         knot_shadow[it.knot_slot] = it.knot_time;
         return;
      end
      t   = it.t_value;
      cnt = (count_shadow > MAX_KNOTS) ? MAX_KNOTS : int'(count_shadow);
      for (int i = 0; i < cnt; i++) begin
         k    = knot_shadow[i];
         take = 1'b1;
         // split mode: keep the knots on t's side of zero, zero on both
         if (mode_shadow == MODE_SPLIT) take = (t >= 0) ? (k >= 0) : (k <= 0);
         if (take) begin
            sel_time[n] = k;
            sel_slot[n] = i;
            n++;
         end
      end
      batch.delete();
      if (mode_shadow == MODE_SPLINE || mode_shadow == MODE_SPLIT)
         blend_cubic(n, t, it.multiplier);
      else
         blend_two(n, t, it.multiplier);
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) weights_due.push_back(batch[i]);
   endfunction

   task automatic report(input string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: offer queued items, hold valid and payload until accepted
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            predict_weights(req_data);
            items_in++;
            if (req_data.cmd == CMD_EVAL) evals_in++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off: once, part way in, stop taking results so the
   // block backs up and stalls its input while the driver keeps offering.
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && items_in == 200) begin
            hold_left <= 400;
            hold_done <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result with the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            weights_out++;
            if (weights_due.size() == 0) begin
               report($sformatf("unexpected item slot %0d weight %0d",
                                rsp_data.shape_slot, rsp_data.weight));
            end else begin
               due = weights_due.pop_front();
               if (rsp_data.shape_slot !== due.shape_slot)
                  report($sformatf("shape_slot %0d, want %0d",
                                   rsp_data.shape_slot, due.shape_slot));
               if (rsp_data.weight !== due.weight)
                  report($sformatf("weight %0d, want %0d (slot %0d)",
                                   rsp_data.weight, due.weight, due.shape_slot));
               if (rsp_data.last !== due.last)
                  report($sformatf("last %0b, want %0b", rsp_data.last, due.last));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_load(input int slot, input int kt);
      req_type r;
      r            = {$urandom, $urandom, $urandom};
      r.cmd        = CMD_LOAD;
      r.knot_slot  = slot[3:0];
      r.knot_time  = kt;
      pending_items.push_back(r);
   endtask

   task automatic push_eval(input int t, input int mul);
      req_type r;
      r            = {$urandom, $urandom, $urandom};
      r.cmd        = CMD_EVAL;
      r.t_value    = t;
      r.multiplier = mul;
      pending_items.push_back(r);
   endtask

   // write one register through a setup and an access phase, then mirror it
   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_MODE) mode_shadow = value[1:0];
      else count_shadow = value[4:0];
   endtask

   // wait until everything sent has come back, then let the block settle
   task automatic drain();
      while (pending_items.size() != 0 || req_valid || weights_due.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // pick a random table for one phase; mostly ascending, now and then shuffled
   task automatic load_table();
      int sh, kt[MAX_KNOTS], tmp, j;
      longint acc;
      sh  = 8 + 4 * $urandom_range(0, 4);
      acc = -(longint'(MAX_KNOTS) * (longint'(2) << sh)) / 2
            + $signed($urandom_range(0, 65535)) - 32768;
      for (int i = 0; i < MAX_KNOTS; i++) begin
         kt[i] = clamp32(acc);
         // a zero step gives a zero-length segment now and then
         acc += longint'($urandom_range(0, 4)) << sh;
         acc += $urandom_range(0, 255);
      end
      if ($urandom_range(0, 5) == 0) begin
         for (int i = 0; i < 4; i++) begin
            j      = $urandom_range(0, MAX_KNOTS - 1);
            tmp    = kt[i];
            kt[i]  = kt[j];
            kt[j]  = tmp;
         end
      end
      for (int i = 0; i < MAX_KNOTS; i++) push_load(i, kt[i]);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int lo, hi, t, mul, cnt;
      longint span;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: extreme end knots, a zero-length segment at zero.
      csr_write(REG_MODE, MODE_SPLINE);
      csr_write(REG_COUNT, 16);
      push_load(0, 32'sh80000000);
      for (int i = 1; i < 15; i++) push_load(i, (i == 8 ? 0 : (i - 7)) * 65536);
      push_load(15, 32'sh7fffffff);
      push_eval(32'sh7fffffff, 32'sh7fffffff);
      push_eval(32'sh80000000, 32'sh80000000);
      push_eval(0, 65536);
      push_eval(98304, 65536);
      push_eval(-212992, -131072);
      drain();
      // two knots fall back to linear, one gives nothing
      csr_write(REG_COUNT, 2);
      push_eval(-65536 * 30000, 65536);
      drain();
      csr_write(REG_COUNT, 1);
      push_eval(0, 65536);
      drain();
      // oversize count clamps to the table size
      csr_write(REG_COUNT, 31);
      csr_write(REG_MODE, MODE_SPLIT);
      push_eval(163840, 65536);
      push_eval(-163840, -65536);
      drain();
      csr_write(REG_MODE, MODE_LINEAR);
      push_eval(327680, 131072);
      drain();
      csr_write(REG_MODE, 2'd3);
      push_eval(-40000, 65536);
      drain();

      // Random phases: new registers and table, then evaluations near the knots.
      for (int p = 0; p < PHASES; p++) begin
         if (p < PHASES / 3) begin
            send_idle = 38;
            recv_idle = 46;
         end else if (p < 2 * PHASES / 3) begin
            send_idle = 46;
            recv_idle = 38;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         csr_write(REG_MODE, $urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0:       cnt = $urandom_range(0, 3);
            1:       cnt = $urandom_range(17, 31);
            2:       cnt = 16;
            default: cnt = $urandom_range(4, 16);
         endcase
         csr_write(REG_COUNT, cnt);
         load_table();
         for (int e = 0; e < 24; e++) begin
            lo   = pending_items[0].knot_time;
            hi   = pending_items[MAX_KNOTS-1].knot_time;
            span = longint'(hi) - longint'(lo) + 1;
            if ($urandom_range(0, 7) == 0) begin
               t = $urandom;
            end else begin
               t = clamp32(longint'(lo) - span / 4
                           + ((longint'($urandom) * span * 3 / 2) >>> 32));
            end
            if ($urandom_range(0, 5) == 0) mul = $urandom;
            else mul = $signed($urandom_range(0, 524288)) - 262144;
            // the odd stray load mid-phase
            if ($urandom_range(0, 15) == 0)
               push_load($urandom_range(0, 15), lo + $urandom_range(0, 65535));
            push_eval(t, mul);
         end
         drain();
      end

      $display("covered %0d items, %0d evaluations, %0d weight items checked",
               items_in, evals_in, weights_out);
      $display("modes spline, split, linear and mode three; counts 0 to 31");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("timeout with %0d weight items still due", weights_due.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
